/* design/i2p_pkg.sv */
// Shared types, constants and helpers for the infix-to-postfix converter.
// Used by i2p_front, i2p_back and infix_to_postfix_converter; no dependencies.
package i2p_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int QDEPTH  = 2;
    localparam int QA_W    = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int TYPE_W   = 3;
    localparam int OP_W     = 3;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [TYPE_W-1:0] {
        KIND_OPERAND  = 3'd0,
        KIND_OPERATOR = 3'd1,
        KIND_OPEN     = 3'd2,
        KIND_CLOSE    = 3'd3,
        KIND_END      = 3'd4
    } kind_t;

    localparam logic [OP_W-1:0] OP_MINUS  = 3'd0;
    localparam logic [OP_W-1:0] OP_PLUS   = 3'd1;
    localparam logic [OP_W-1:0] OP_TIMES  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIVIDE = 3'd3;
    localparam logic [OP_W-1:0] OP_POWER  = 3'd4;
    localparam logic [OP_W-1:0] OP_MARK   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OPEN     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        kind_t               kind;
        logic [OP_W-1:0]     op;
        logic [DATA_W-1:0]   num;
        logic [DATA_W-1:0]   den;
    } token_t;

    // True when a stacked operator must be output before the incoming one is pushed.
    function automatic logic op_pops(input logic [OP_W-1:0] stacked,
                                     input logic [OP_W-1:0] incoming);
        logic [OP_W-2:0] p_stk;
        logic [OP_W-2:0] p_in;
        p_stk = stacked[OP_W-1:1];
        p_in  = incoming[OP_W-1:1];
        return (p_stk > p_in) || ((p_stk == p_in) && (incoming != OP_POWER));
    endfunction

endpackage

/* design/i2p_front.sv */
// Front end of the converter: takes input beats, drops meaningless tokens
// and queues the rest for the back end. Depends on i2p_pkg.
module i2p_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2p_pkg::TYPE_W-1:0]    s_req_type,
    input  logic [i2p_pkg::OP_W-1:0]      s_operator_code,
    input  logic [i2p_pkg::DATA_W-1:0]    s_operand_num,
    input  logic [i2p_pkg::DATA_W-1:0]    s_operand_den,
    output logic                          q_valid,
    input  logic                          q_ready,
    output i2p_pkg::token_t               q_tok
);
    import i2p_pkg::*;

    token_t            queue_reg [QDEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              tok_ok;
    logic              wr_en;
    logic              rd_en;
    token_t            tok_in;

    assign s_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_tok   = queue_reg[rd_ptr_reg];

    // Unknown kinds and unknown operator codes are consumed without effect.
    always_comb begin
        tok_ok = 1'b0;
        case (s_req_type)
            KIND_OPERAND, KIND_OPEN, KIND_CLOSE, KIND_END: tok_ok = 1'b1;
            KIND_OPERATOR: tok_ok = (s_operator_code <= OP_POWER);
            default:       tok_ok = 1'b0;
        endcase
        tok_in.kind = kind_t'(s_req_type);
        tok_in.op   = s_operator_code;
        tok_in.num  = s_operand_num;
        tok_in.den  = s_operand_den;
    end

    assign wr_en = s_valid && s_ready && tok_ok;
    assign rd_en = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QA_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QA_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            queue_reg[wr_ptr_reg] <= tok_in;
        end
    end

endmodule

/* design/i2p_back.sv */
// Back end of the converter: operator stack, pop sequencer and output register.
// Depends on i2p_pkg; fed by the token queue in i2p_front.
module i2p_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  i2p_pkg::token_t               q_tok,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_out_kind,
    output logic [i2p_pkg::OP_W-1:0]      m_out_op,
    output logic [i2p_pkg::DATA_W-1:0]    m_out_num,
    output logic [i2p_pkg::DATA_W-1:0]    m_out_den,
    output logic [i2p_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_last
);
    import i2p_pkg::*;

    logic [OP_W-1:0]     stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                held_valid_reg, held_valid_next;
    logic [OP_W-1:0]     held_op_reg, held_op_next;
    logic                mark_seen_reg, mark_seen_next;

    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [OP_W-1:0]     m_op_reg;
    logic [DATA_W-1:0]   m_num_reg;
    logic [DATA_W-1:0]   m_den_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_last_reg;

    logic                out_free;
    logic                act;
    logic                empty;
    logic                full;
    logic [SP_W-1:0]     top_idx;
    logic [OP_W-1:0]     top;
    logic                do_pop;
    logic                do_push;
    logic [OP_W-1:0]     push_code;
    logic                hold_load;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic                emit;
    logic                e_kind;
    logic [OP_W-1:0]     e_op;
    logic [DATA_W-1:0]   e_num;
    logic [DATA_W-1:0]   e_den;
    logic [STATUS_W-1:0] e_status;
    logic                e_last;

    assign out_free = !m_valid_reg || m_ready;
    assign act      = q_valid && out_free;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign top_idx  = SP_W'(count_reg - CNT_W'(1));
    assign top      = stack_reg[top_idx];

    // One stack action per cycle if the output is free; a popped operator is held
    // back so that a token's final result can be marked once the stack walk ends.
    always_comb begin
        do_pop         = 1'b0;
        do_push        = 1'b0;
        push_code      = q_tok.op;
        hold_load      = 1'b0;
        fin            = 1'b0;
        fin_status     = ST_OK;
        mark_seen_next = mark_seen_reg;
        emit           = 1'b0;
        e_kind         = 1'b0;
        e_op           = '0;
        e_num          = '0;
        e_den          = '0;
        e_status       = ST_OK;
        e_last         = 1'b0;
        q_ready        = 1'b0;

        if (act) begin
            case (q_tok.kind)
                KIND_OPERAND: begin
                    emit    = 1'b1;
                    e_num   = q_tok.num;
                    e_den   = q_tok.den;
                    e_last  = 1'b1;
                    q_ready = 1'b1;
                end
                KIND_OPERATOR: begin
                    if (!empty && (top != OP_MARK) && op_pops(top, q_tok.op)) begin
                        do_pop    = 1'b1;
                        hold_load = 1'b1;
                    end else begin
                        fin = 1'b1;
                        if (full) begin
                            fin_status = ST_OVERFLOW;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                end
                KIND_OPEN: begin
                    fin       = 1'b1;
                    push_code = OP_MARK;
                    if (full) begin
                        fin_status = ST_OVERFLOW;
                    end else begin
                        do_push = 1'b1;
                    end
                end
                KIND_CLOSE: begin
                    if (empty) begin
                        fin        = 1'b1;
                        fin_status = ST_CLOSE;
                    end else if (top == OP_MARK) begin
                        do_pop = 1'b1;
                        fin    = 1'b1;
                    end else begin
                        do_pop    = 1'b1;
                        hold_load = 1'b1;
                    end
                end
                KIND_END: begin
                    if (empty) begin
                        fin            = 1'b1;
                        fin_status     = mark_seen_reg ? ST_OPEN : ST_OK;
                        mark_seen_next = 1'b0;
                    end else if (top == OP_MARK) begin
                        do_pop         = 1'b1;
                        mark_seen_next = 1'b1;
                    end else begin
                        do_pop    = 1'b1;
                        hold_load = 1'b1;
                    end
                end
                default: begin
                    q_ready = 1'b1;
                end
            endcase

            if (hold_load && held_valid_reg) begin
                emit   = 1'b1;
                e_kind = 1'b1;
                e_op   = held_op_reg;
            end

            if (fin) begin
                q_ready = 1'b1;
                if (held_valid_reg) begin
                    emit     = 1'b1;
                    e_kind   = 1'b1;
                    e_op     = held_op_reg;
                    e_status = fin_status;
                    e_last   = 1'b1;
                end else if (fin_status != ST_OK) begin
                    emit     = 1'b1;
                    e_status = fin_status;
                    e_last   = 1'b1;
                end
            end
        end
    end

    always_comb begin
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_op_next    = held_op_reg;
        if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (do_push) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (hold_load) begin
            held_valid_next = 1'b1;
            held_op_next    = top;
        end else if (fin) begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            mark_seen_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            mark_seen_reg  <= mark_seen_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        held_op_reg <= held_op_next;
        if (do_push) begin
            stack_reg[count_reg[SP_W-1:0]] <= push_code;
        end
        if (emit) begin
            m_kind_reg   <= e_kind;
            m_op_reg     <= e_op;
            m_num_reg    <= e_num;
            m_den_reg    <= e_den;
            m_status_reg <= e_status;
            m_last_reg   <= e_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_kind = m_kind_reg;
    assign m_out_op   = m_op_reg;
    assign m_out_num  = m_num_reg;
    assign m_out_den  = m_den_reg;
    assign m_status   = m_status_reg;
    assign m_last     = m_last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("operator stack count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |-> !full)
        else $error("push into a full operator stack");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> !empty)
        else $error("pop from an empty operator stack");

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result written over an undelivered beat");

    a_held_token: assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> (q_valid && (q_tok.kind == KIND_OPERATOR ||
                                        q_tok.kind == KIND_CLOSE ||
                                        q_tok.kind == KIND_END)))
        else $error("held operator without a popping token in progress");

endmodule

/* design/infix_to_postfix_converter.sv */
// Top level of the infix-to-postfix converter: front end, token queue, back end.
// Depends on i2p_pkg, i2p_front and i2p_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    req_type, operator_code, operand_num, operand_den
//   m_        out        m_valid/m_ready    out_kind, out_op, out_num, out_den, status, last
//
// The front end takes one beat per cycle while its two-entry token queue has room.
// The back end handles each operand, open parenthesis or pushed operator directly, and each
// stack pop as a step of its own; end tokens and unmatched close tokens finish with a last step.
// The operator stack, with one pop or push per cycle while the m_ channel is free, sets the
// rate. Reset is synchronous and active low and empties the stack.
// A stalled m_ channel holds its beat and stops the back end; the queue absorbs input.
module infix_to_postfix_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2p_pkg::TYPE_W-1:0]    s_req_type,
    input  logic [i2p_pkg::OP_W-1:0]      s_operator_code,
    input  logic [i2p_pkg::DATA_W-1:0]    s_operand_num,
    input  logic [i2p_pkg::DATA_W-1:0]    s_operand_den,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_out_kind,
    output logic [i2p_pkg::OP_W-1:0]      m_out_op,
    output logic [i2p_pkg::DATA_W-1:0]    m_out_num,
    output logic [i2p_pkg::DATA_W-1:0]    m_out_den,
    output logic [i2p_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_last
);
    import i2p_pkg::*;

    logic   q_valid;
    logic   q_ready;
    token_t q_tok;

    i2p_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_operator_code (s_operator_code),
        .s_operand_num   (s_operand_num),
        .s_operand_den   (s_operand_den),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_tok           (q_tok)
    );

    i2p_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_tok      (q_tok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_kind (m_out_kind),
        .m_out_op   (m_out_op),
        .m_out_num  (m_out_num),
        .m_out_den  (m_out_den),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule

/* tb/tb_infix_to_postfix_converter.sv */
// Self-checking testbench for infix_to_postfix_converter: a scoreboard class predicts
// the postfix beats of every accepted token, and plain tasks drive the s_ channel.
// Depends on i2p_pkg and the infix_to_postfix_converter RTL.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;
    import i2p_pkg::*;

    localparam logic BEAT_OPERAND  = 1'b0;
    localparam logic BEAT_OPERATOR = 1'b1;

    typedef struct {
        logic                kind;
        logic [OP_W-1:0]     op;
        logic [DATA_W-1:0]   num;
        logic [DATA_W-1:0]   den;
        logic [STATUS_W-1:0] status;
        logic                last;
    } postfix_beat_t;

    class postfix_scoreboard;
        logic [OP_W-1:0] op_stack [STACK_DEPTH];
        int              depth;
        postfix_beat_t   awaited[$];
        int              errors;
        int              tokens_used;

        function new();
            depth       = 0;
            errors      = 0;
            tokens_used = 0;
        endfunction

        function logic [1:0] rank(logic [OP_W-1:0] code);
            return code[2:1];
        endfunction

        function postfix_beat_t beat(logic kind, logic [OP_W-1:0] op,
                                     logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
            postfix_beat_t b;
            b.kind   = kind;
            b.op     = op;
            b.num    = num;
            b.den    = den;
            b.status = ST_OK;
            b.last   = 1'b0;
            return b;
        endfunction

        function bit stack_push(logic [OP_W-1:0] code);
            if (depth >= STACK_DEPTH)
                return 1'b0;
            op_stack[depth] = code;
            depth++;
            return 1'b1;
        endfunction

        // Works out the beats that one accepted token causes and queues them.
        function void note_token(logic [TYPE_W-1:0] kind, logic [OP_W-1:0] code,
                                 logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
            postfix_beat_t       produced[$];
            logic [STATUS_W-1:0] st;
            logic [OP_W-1:0]     top;
            bit                  found;
            st    = ST_OK;
            found = 1'b0;
            case (kind)
                KIND_OPERAND: produced.push_back(beat(BEAT_OPERAND, '0, num, den));
                KIND_OPERATOR: begin
                    if (code > OP_POWER)
                        return;
                    while (depth > 0) begin
                        top = op_stack[depth-1];
                        if (top == OP_MARK)
                            break;
                        // Power is right-associative, so an equal rank only pops for the others.
                        if (rank(top) > rank(code) ||
                            (rank(top) == rank(code) && code != OP_POWER)) begin
                            depth--;
                            produced.push_back(beat(BEAT_OPERATOR, top, '0, '0));
                        end else begin
                            break;
                        end
                    end
                    if (!stack_push(code))
                        st = ST_OVERFLOW;
                end
                KIND_OPEN: begin
                    if (!stack_push(OP_MARK))
                        st = ST_OVERFLOW;
                end
                KIND_CLOSE: begin
                    while (depth > 0 && !found) begin
                        depth--;
                        top = op_stack[depth];
                        if (top == OP_MARK)
                            found = 1'b1;
                        else
                            produced.push_back(beat(BEAT_OPERATOR, top, '0, '0));
                    end
                    if (!found)
                        st = ST_CLOSE;
                end
                KIND_END: begin
                    while (depth > 0) begin
                        depth--;
                        top = op_stack[depth];
                        if (top == OP_MARK)
                            st = ST_OPEN;
                        else
                            produced.push_back(beat(BEAT_OPERATOR, top, '0, '0));
                    end
                end
                default: return;
            endcase
            tokens_used++;
            // A status with nothing else to carry it gets an empty operand beat of its own.
            if (st != ST_OK && produced.size() == 0)
                produced.push_back(beat(BEAT_OPERAND, '0, '0, '0));
            if (produced.size() > 0) begin
                produced[produced.size()-1].status = st;
                produced[produced.size()-1].last   = 1'b1;
            end
            foreach (produced[i])
                awaited.push_back(produced[i]);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(postfix_beat_t got);
            postfix_beat_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected beat, kind %0d op %0d num %0d den %0d status %0d",
                         $time, got.kind, got.op, got.num, got.den, got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("out_kind", 32'(want.kind), 32'(got.kind));
            compare("out_op", 32'(want.op), 32'(got.op));
            compare("out_num", 32'(want.num), 32'(got.num));
            compare("out_den", 32'(want.den), 32'(got.den));
            compare("status", 32'(want.status), 32'(got.status));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [TYPE_W-1:0]   s_req_type;
    logic [OP_W-1:0]     s_operator_code;
    logic [DATA_W-1:0]   s_operand_num;
    logic [DATA_W-1:0]   s_operand_den;
    logic                m_valid;
    logic                m_ready;
    logic                m_out_kind;
    logic [OP_W-1:0]     m_out_op;
    logic [DATA_W-1:0]   m_out_num;
    logic [DATA_W-1:0]   m_out_den;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    postfix_scoreboard sb = new();
    bit                gaps_on;

    infix_to_postfix_converter DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_operator_code (s_operator_code),
        .s_operand_num   (s_operand_num),
        .s_operand_den   (s_operand_den),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_op        (m_out_op),
        .m_out_num       (m_out_num),
        .m_out_den       (m_out_den),
        .m_status        (m_status),
        .m_last          (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_token(logic [TYPE_W-1:0] kind, logic [OP_W-1:0] code,
                              logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_req_type      = kind;
        s_operator_code = code;
        s_operand_num   = num;
        s_operand_den   = den;
        s_valid         = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_token(kind, code, num, den);
        @(negedge aclk);
    endtask

    task automatic send_kind(logic [TYPE_W-1:0] kind);
        send_token(kind, OP_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
    endtask

    task automatic send_operator(logic [OP_W-1:0] code);
        send_token(KIND_OPERATOR, code, DATA_W'($urandom), DATA_W'($urandom));
    endtask

    task automatic send_operand();
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        num = DATA_W'($urandom);
        den = DATA_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            num = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 7) == 0)
            den = $urandom_range(0, 1) ? '1 : '0;
        send_token(KIND_OPERAND, OP_W'($urandom), num, den);
    endtask

    // A well-formed expression with random nesting; a broken one gets stray tokens
    // and may leave its parentheses open or omit the end token.
    task automatic send_expression(int terms, bit broken);
        int nest;
        nest = 0;
        for (int i = 0; i < terms; i++) begin
            while (nest < 6 && $urandom_range(0, 3) == 0) begin
                send_kind(KIND_OPEN);
                nest++;
            end
            send_operand();
            while (nest > 0 && $urandom_range(0, 2) == 0) begin
                send_kind(KIND_CLOSE);
                nest--;
            end
            if (broken && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        send_kind(KIND_CLOSE);
                        if (nest > 0)
                            nest--;
                    end
                    1: send_operator(OP_W'($urandom_range(OP_MINUS, OP_POWER)));
                    default: send_operand();
                endcase
            end
            if (i != terms - 1)
                send_operator(OP_W'($urandom_range(OP_MINUS, OP_POWER)));
        end
        if (!broken || $urandom_range(0, 1) == 0) begin
            while (nest > 0) begin
                send_kind(KIND_CLOSE);
                nest--;
            end
        end
        if (!broken || $urandom_range(0, 1) == 0)
            send_kind(KIND_END);
    endtask

    // Nesting of 14 to 20 opens and power operators, near or past the stack depth, then a full flush.
    task automatic send_deep_nest();
        repeat ($urandom_range(14, 20)) begin
            if ($urandom_range(0, 1) == 0)
                send_kind(KIND_OPEN);
            else
                send_operator(OP_POWER);
        end
        send_operand();
        send_operator(OP_W'($urandom_range(OP_MINUS, OP_POWER)));
        send_operand();
        send_kind(KIND_END);
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        postfix_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind   = m_out_kind;
            got.op     = m_out_op;
            got.num    = m_out_num;
            got.den    = m_out_den;
            got.status = m_status;
            got.last   = m_last;
            sb.check_beat(got);
        end
    end

    initial begin
        #5_000_000;
        $display("infix_to_postfix_converter test failed");
        $finish;
    end

    initial begin
        int seq_no;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = '0;
        s_operator_code = '0;
        s_operand_num   = '0;
        s_operand_den   = '0;
        gaps_on         = 1'b0;
        seq_no          = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part: field extremes, every operator, stray tokens, unmatched close and open.
        send_token(KIND_OPERAND, OP_MARK, '0, '0);
        send_operator(OP_MINUS);
        send_token(KIND_OPERAND, '0, '1, '1);
        send_operator(OP_TIMES);
        send_kind(KIND_OPEN);
        send_token(KIND_OPERAND, '0, 16'd1234, 16'd5);
        send_operator(OP_PLUS);
        send_token(KIND_OPERAND, '0, 16'd7, 16'd1);
        send_kind(KIND_CLOSE);
        send_operator(OP_POWER);
        send_token(KIND_OPERAND, '0, 16'd2, 16'd3);
        send_operator(OP_POWER);
        send_token(KIND_OPERAND, '0, '0, '1);
        send_operator(OP_DIVIDE);
        send_token(KIND_OPERAND, '0, '1, '0);
        send_kind(KIND_END);
        send_kind(KIND_CLOSE);
        send_token(3'd5, '0, '0, '0);
        send_token(3'd7, 3'd7, '1, '1);
        send_operator(3'd7);
        send_operator(3'd5);
        send_kind(KIND_END);
        send_kind(KIND_OPEN);
        send_operator(OP_PLUS);
        send_kind(KIND_END);
        send_operator(OP_TIMES);
        send_kind(KIND_CLOSE);

        // Random part; the closing stretch runs without any idling.
        while (sb.tokens_used < 520) begin
            gaps_on = (sb.tokens_used < 440) && ($urandom_range(0, 3) != 0);
            if (seq_no == 0) begin
                send_deep_nest();
            end else begin
                case ($urandom_range(0, 9))
                    7: send_expression($urandom_range(1, 6), 1'b1);
                    8: repeat ($urandom_range(1, 4))
                        send_token(TYPE_W'($urandom_range(0, 7)), OP_W'($urandom_range(0, 7)),
                                   DATA_W'($urandom), DATA_W'($urandom));
                    9: send_deep_nest();
                    default: send_expression($urandom_range(1, 8), 1'b0);
                endcase
            end
            seq_no++;
        end
        s_valid = 1'b0;
        gaps_on = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (sb.outstanding() != 0)
            $display("%0t: %0d expected beats never arrived", $time, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("infix_to_postfix_converter test passed");
        end else begin
            $display("infix_to_postfix_converter test failed");
        end
        $finish;
    end

endmodule
